>>> rtl/ers_pkg.sv
// ers_pkg: widths, register indexes, phase codes and shared structs of the
// reverse arming sequencer; no dependencies, compiled first
package ers_pkg;

    localparam int CHAN_W     = 1;
    localparam int PULSE_W    = 12;
    localparam int BAND_W     = 10;
    localparam int TIME_W     = 16;
    localparam int STAMP_W    = 32;
    localparam int PHASE_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int CHANNELS_DEF = 2;

    localparam logic [PULSE_W-1:0] MIN_PULSE_RST     = 12'd1000;
    localparam logic [PULSE_W-1:0] MAX_PULSE_RST     = 12'd2000;
    localparam logic [PULSE_W-1:0] NEUTRAL_PULSE_RST = 12'd1500;
    localparam logic [BAND_W-1:0]  HALF_BAND_RST     = 10'd30;
    localparam logic [TIME_W-1:0]  BRAKE_TIME_RST    = 16'd100;
    localparam logic [TIME_W-1:0]  REVERSE_DELAY_RST = 16'd200;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_PULSE     = 3'd0,
        REG_MAX_PULSE     = 3'd1,
        REG_NEUTRAL_PULSE = 3'd2,
        REG_HALF_BAND     = 3'd3,
        REG_BRAKE_TIME    = 3'd4,
        REG_REVERSE_DELAY = 3'd5
    } t_reg_idx;

    typedef enum logic [PHASE_W-1:0] {
        PH_FORWARD      = 3'd0,
        PH_NEUTRAL      = 3'd1,
        PH_REV_START    = 3'd2,
        PH_BRAKE        = 3'd3,
        PH_REV_PAUSE    = 3'd4,
        PH_REV_PASS     = 3'd5
    } t_phase;

    typedef struct packed {
        logic [PULSE_W-1:0] min_pulse;
        logic [PULSE_W-1:0] max_pulse;
        logic [PULSE_W-1:0] neutral_pulse;
        logic [BAND_W-1:0]  half_band;
        logic [TIME_W-1:0]  brake_time;
        logic [TIME_W-1:0]  reverse_delay;
    } t_cfg;

    typedef struct packed {
        logic [CHAN_W-1:0]  channel;
        logic [PULSE_W-1:0] request_us;
        logic [STAMP_W-1:0] now_ms;
    } t_cmd;

    typedef struct packed {
        logic [CHAN_W-1:0]  out_channel;
        logic [PULSE_W-1:0] pulse_us;
        t_phase             phase;
    } t_res;

    typedef struct packed {
        logic               armed;
        logic [STAMP_W-1:0] start_ms;
    } t_chan_state;

    typedef struct packed {
        logic wr_en;
        logic armed;
        logic load_start;
    } t_state_upd;

endpackage

>>> rtl/ers_if.sv
// ers_if: valid/ready channel interfaces for commands, results and
// configuration writes; depends on ers_pkg
interface ers_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [ers_pkg::CHAN_W-1:0]   channel;
    logic [ers_pkg::PULSE_W-1:0]  request_us;
    logic [ers_pkg::STAMP_W-1:0]  now_ms;

    modport source (output valid, output channel, output request_us, output now_ms,
                    input ready);
    modport sink   (input valid, input channel, input request_us, input now_ms,
                    output ready);
endinterface

interface ers_res_if;
    logic                         valid;
    logic                         ready;
    logic [ers_pkg::CHAN_W-1:0]   out_channel;
    logic [ers_pkg::PULSE_W-1:0]  pulse_us;
    logic [ers_pkg::PHASE_W-1:0]  phase;

    modport source (output valid, output out_channel, output pulse_us, output phase,
                    input ready);
    modport sink   (input valid, input out_channel, input pulse_us, input phase,
                    output ready);
endinterface

interface ers_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ers_pkg::CFG_IDX_W-1:0]  index;
    logic [ers_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/ers_cfg_regs.sv
// ers_cfg_regs: configuration register file, written over the cfg channel
// depends on ers_pkg and ers_if
module ers_cfg_regs (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ers_cfg_if.sink          i_cfg,
    output ers_pkg::t_cfg    o_cfg
);

    ers_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_pulse     <= ers_pkg::MIN_PULSE_RST;
            r_cfg.max_pulse     <= ers_pkg::MAX_PULSE_RST;
            r_cfg.neutral_pulse <= ers_pkg::NEUTRAL_PULSE_RST;
            r_cfg.half_band     <= ers_pkg::HALF_BAND_RST;
            r_cfg.brake_time    <= ers_pkg::BRAKE_TIME_RST;
            r_cfg.reverse_delay <= ers_pkg::REVERSE_DELAY_RST;
        end else if (i_cfg.valid) begin
            unique case (ers_pkg::t_reg_idx'(i_cfg.index))
                ers_pkg::REG_MIN_PULSE:     r_cfg.min_pulse <= i_cfg.data[ers_pkg::PULSE_W-1:0];
                ers_pkg::REG_MAX_PULSE:     r_cfg.max_pulse <= i_cfg.data[ers_pkg::PULSE_W-1:0];
                ers_pkg::REG_NEUTRAL_PULSE: begin
                    r_cfg.neutral_pulse <= i_cfg.data[ers_pkg::PULSE_W-1:0];
                end
                ers_pkg::REG_HALF_BAND:     r_cfg.half_band <= i_cfg.data[ers_pkg::BAND_W-1:0];
                ers_pkg::REG_BRAKE_TIME:    r_cfg.brake_time <= i_cfg.data[ers_pkg::TIME_W-1:0];
                ers_pkg::REG_REVERSE_DELAY: begin
                    r_cfg.reverse_delay <= i_cfg.data[ers_pkg::TIME_W-1:0];
                end
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/ers_chan_state.sv
// ers_chan_state: per-channel armed flag and reverse start timestamp
// depends on ers_pkg
module ers_chan_state #(
    parameter int CHANNELS = ers_pkg::CHANNELS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [ers_pkg::CHAN_W-1:0]    i_channel,
    input  logic [ers_pkg::STAMP_W-1:0]   i_now_ms,
    input  ers_pkg::t_state_upd           i_upd,
    output ers_pkg::t_chan_state          o_state
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic                        r_armed    [CHANNELS];
    logic [ers_pkg::STAMP_W-1:0] r_start_ms [CHANNELS];
    logic [IDX_W-1:0]            w_sel;

    // channel modulo CHANNELS: the one-bit channel is below any count of two or more
    assign w_sel = (CHANNELS > 1) ? IDX_W'(i_channel) : '0;

    assign o_state.armed    = r_armed[w_sel];
    assign o_state.start_ms = r_start_ms[w_sel];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_armed[i]    <= 1'b1;
                r_start_ms[i] <= '0;
            end
        end else if (i_upd.wr_en) begin
            r_armed[w_sel] <= i_upd.armed;
            if (i_upd.load_start) begin
                r_start_ms[w_sel] <= i_now_ms;
            end
        end
    end

endmodule

>>> rtl/ers_decide.sv
// ers_decide: clamp, band test and reverse timing for one command
// depends on ers_pkg
module ers_decide (
    input  ers_pkg::t_cfg         i_cfg,
    input  ers_pkg::t_cmd         i_cmd,
    input  ers_pkg::t_chan_state  i_state,
    output ers_pkg::t_res         o_res,
    output ers_pkg::t_state_upd   o_upd
);

    logic [ers_pkg::PULSE_W-1:0] w_clamp;
    logic [ers_pkg::PULSE_W:0]   w_hi_edge;
    logic [ers_pkg::PULSE_W:0]   w_c_plus_h;
    logic                        w_fwd;
    logic                        w_above_lo;
    logic [ers_pkg::STAMP_W-1:0] w_elapsed;
    logic                        w_past_delay;
    logic                        w_past_brake;

    always_comb begin
        if (i_cmd.request_us < i_cfg.min_pulse) begin
            w_clamp = i_cfg.min_pulse;
        end else if (i_cmd.request_us > i_cfg.max_pulse) begin
            w_clamp = i_cfg.max_pulse;
        end else begin
            w_clamp = i_cmd.request_us;
        end
    end

    // c > N - H is tested as c + H > N to stay unsigned
    assign w_hi_edge  = {1'b0, i_cfg.neutral_pulse} + (ers_pkg::PULSE_W+1)'(i_cfg.half_band);
    assign w_c_plus_h = {1'b0, w_clamp} + (ers_pkg::PULSE_W+1)'(i_cfg.half_band);
    assign w_fwd      = {1'b0, w_clamp} >= w_hi_edge;
    assign w_above_lo = w_c_plus_h > {1'b0, i_cfg.neutral_pulse};

    assign w_elapsed    = i_cmd.now_ms - i_state.start_ms;
    assign w_past_delay = w_elapsed > ers_pkg::STAMP_W'(i_cfg.reverse_delay);
    assign w_past_brake = w_elapsed > ers_pkg::STAMP_W'(i_cfg.brake_time);

    always_comb begin
        o_res.out_channel = i_cmd.channel;
        o_upd.wr_en       = 1'b0;
        o_upd.armed       = i_state.armed;
        o_upd.load_start  = 1'b0;
        if (w_fwd) begin
            o_res.pulse_us = w_clamp;
            o_res.phase    = ers_pkg::PH_FORWARD;
            o_upd.wr_en    = 1'b1;
            o_upd.armed    = 1'b1;
        end else if (w_above_lo) begin
            o_res.pulse_us = i_cfg.neutral_pulse;
            o_res.phase    = ers_pkg::PH_NEUTRAL;
            o_upd.wr_en    = 1'b1;
            o_upd.armed    = 1'b1;
        end else if (i_state.armed) begin
            o_res.pulse_us   = i_cfg.neutral_pulse;
            o_res.phase      = ers_pkg::PH_REV_START;
            o_upd.wr_en      = 1'b1;
            o_upd.armed      = 1'b0;
            o_upd.load_start = 1'b1;
        end else if (w_past_delay) begin
            o_res.pulse_us = w_clamp;
            o_res.phase    = ers_pkg::PH_REV_PASS;
        end else if (w_past_brake) begin
            o_res.pulse_us = i_cfg.neutral_pulse;
            o_res.phase    = ers_pkg::PH_REV_PAUSE;
        end else begin
            o_res.pulse_us = i_cfg.min_pulse;
            o_res.phase    = ers_pkg::PH_BRAKE;
        end
    end

endmodule

>>> rtl/esc_reverse_arming_sequencer.sv
// esc_reverse_arming_sequencer: top level, command and result registers
// around the decision logic; depends on ers_pkg, ers_if and the ers modules
//
//  channel  | dir | carries                                  | transfer when
//  ---------+-----+------------------------------------------+----------------------
//  i_cmd    | in  | channel, request_us, now_ms              | valid && ready
//  o_res    | out | out_channel, pulse_us, phase             | valid && ready
//  i_cfg    | in  | index (register number), data            | valid (ready held high)
//
//  one command per cycle sustained while o_res is ready; a command is taken into
//  the command register at its transfer, then moves into the result register
//  the per-channel state is read and written in the cycle a command moves
//  into the result register, so back-to-back commands on one channel chain
//  synchronous active-low reset arms every channel, clears the timestamps,
//  loads register defaults and empties both stages
//  a stalled o_res holds the result; i_cmd keeps taking one more command
//  into the command register before ready drops
module esc_reverse_arming_sequencer #(
    parameter int CHANNELS = ers_pkg::CHANNELS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ers_cmd_if.sink  i_cmd,
    ers_res_if.source o_res,
    ers_cfg_if.sink  i_cfg
);

    ers_pkg::t_cfg         w_cfg;
    ers_pkg::t_chan_state  w_state;
    ers_pkg::t_res         w_res;
    ers_pkg::t_state_upd   w_upd;
    ers_pkg::t_state_upd   w_upd_gated;

    // command register
    logic                  r_cmd_valid;
    ers_pkg::t_cmd         r_cmd;
    // result register
    logic                  r_res_valid;
    ers_pkg::t_res         r_res;

    logic                  w_advance;
    logic                  w_in_ready;

    ers_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    ers_chan_state #(
        .CHANNELS (CHANNELS)
    ) u_chan_state (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_channel (r_cmd.channel),
        .i_now_ms  (r_cmd.now_ms),
        .i_upd     (w_upd_gated),
        .o_state   (w_state)
    );

    ers_decide u_decide (
        .i_cfg   (w_cfg),
        .i_cmd   (r_cmd),
        .i_state (w_state),
        .o_res   (w_res),
        .o_upd   (w_upd)
    );

    // command moves on when the result register is empty or being drained
    assign w_advance  = r_cmd_valid && (!r_res_valid || o_res.ready);
    assign w_in_ready = !r_cmd_valid || w_advance;

    // state only changes for a command that actually moves on
    always_comb begin
        w_upd_gated       = w_upd;
        w_upd_gated.wr_en = w_upd.wr_en && w_advance;
    end

    assign i_cmd.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_cmd_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_cmd.valid) begin
            r_cmd.channel    <= i_cmd.channel;
            r_cmd.request_us <= i_cmd.request_us;
            r_cmd.now_ms     <= i_cmd.now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_advance) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_res <= w_res;
        end
    end

    assign o_res.valid       = r_res_valid;
    assign o_res.out_channel = r_res.out_channel;
    assign o_res.pulse_us    = r_res.pulse_us;
    assign o_res.phase       = r_res.phase;

endmodule

>>> dv/esc_reverse_arming_sequencer_tb.sv
`timescale 1ns / 1ps
// esc_reverse_arming_sequencer_tb: self-checking bench for the reverse arming sequencer,
// directed and random command streams scored against a behavioral predictor
// depends on ers_pkg, ers_if and the sequencer rtl
module esc_reverse_arming_sequencer_tb;

    localparam int CLK_HALF_NS   = 5;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 8;       // two pipeline stages plus margin
    localparam int LIMIT_CYCLES  = 200000;
    localparam int MAX_GAP       = 7;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 135;
    localparam int NCH           = ers_pkg::CHANNELS_DEF;
    localparam int PULSE_MAX     = (1 << ers_pkg::PULSE_W) - 1;

    // indexes with no register behind them, writes must be dropped
    localparam logic [ers_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [ers_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    // register defaults in field order: min, max, neutral, half band, brake, delay
    localparam ers_pkg::t_cfg RESET_SETTINGS = '{
        ers_pkg::MIN_PULSE_RST, ers_pkg::MAX_PULSE_RST, ers_pkg::NEUTRAL_PULSE_RST,
        ers_pkg::HALF_BAND_RST, ers_pkg::BRAKE_TIME_RST, ers_pkg::REVERSE_DELAY_RST};

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    ers_cmd_if cmd_if ();
    ers_res_if res_if ();
    ers_cfg_if cfg_if ();

    esc_reverse_arming_sequencer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // predictor state: register shadow plus per-channel arming and reverse timestamp
    ers_pkg::t_cfg               shadow;
    logic                        armed_q     [NCH];
    logic [ers_pkg::STAMP_W-1:0] rev_start_q [NCH];
    ers_pkg::t_res               expected_q  [$];

    // stimulus state: per-channel millisecond clock and remaining reverse burst
    logic [ers_pkg::STAMP_W-1:0] chan_clock  [NCH];
    int                          rev_burst   [NCH];

    bit  idle_en;            // random gaps and stalls on both sides when set
    int  rx_stall_left;      // per-result stall of the receiver
    int  rx_hold_left;       // long receiver hold-off, counted down by the receiver
    int  mismatch_cnt;
    int  cycle_cnt;
    ers_pkg::t_res got_exp;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic ers_pkg::t_res predict_pulse(logic [ers_pkg::CHAN_W-1:0] ch,
                                                    logic [ers_pkg::PULSE_W-1:0] req,
                                                    logic [ers_pkg::STAMP_W-1:0] now);
        ers_pkg::t_res               r;
        logic [ers_pkg::PULSE_W-1:0] clamped;
        logic [ers_pkg::STAMP_W-1:0] elapsed;
        int                          upper_edge;
        int                          lower_edge;
        int                          slot;
        slot = int'(ch) % NCH;
        // min tested first: inverted limits give min below it, max otherwise
        if (req < shadow.min_pulse) begin
            clamped = shadow.min_pulse;
        end else if (req > shadow.max_pulse) begin
            clamped = shadow.max_pulse;
        end else begin
            clamped = req;
        end
        // band edges as signed sums, the lower one may go negative
        upper_edge = int'(shadow.neutral_pulse) + int'(shadow.half_band);
        lower_edge = int'(shadow.neutral_pulse) - int'(shadow.half_band);
        r.out_channel = ch;
        if (int'(clamped) >= upper_edge) begin
            armed_q[slot] = 1'b1;
            r.pulse_us    = clamped;
            r.phase       = ers_pkg::PH_FORWARD;
        end else if (int'(clamped) > lower_edge) begin
            armed_q[slot] = 1'b1;
            r.pulse_us    = shadow.neutral_pulse;
            r.phase       = ers_pkg::PH_NEUTRAL;
        end else if (armed_q[slot]) begin
            armed_q[slot]     = 1'b0;
            rev_start_q[slot] = now;
            r.pulse_us        = shadow.neutral_pulse;
            r.phase           = ers_pkg::PH_REV_START;
        end else begin
            // wrapping 32-bit difference, pass-through tested before brake
            elapsed = now - rev_start_q[slot];
            if (elapsed > ers_pkg::STAMP_W'(shadow.reverse_delay)) begin
                r.pulse_us = clamped;
                r.phase    = ers_pkg::PH_REV_PASS;
            end else if (elapsed > ers_pkg::STAMP_W'(shadow.brake_time)) begin
                r.pulse_us = shadow.neutral_pulse;
                r.phase    = ers_pkg::PH_REV_PAUSE;
            end else begin
                r.pulse_us = shadow.min_pulse;
                r.phase    = ers_pkg::PH_BRAKE;
            end
        end
        return r;
    endfunction

    function automatic void shadow_write(logic [ers_pkg::CFG_IDX_W-1:0] idx,
                                         logic [ers_pkg::CFG_DATA_W-1:0] d);
        case (idx)
            ers_pkg::REG_MIN_PULSE:     shadow.min_pulse     = d[ers_pkg::PULSE_W-1:0];
            ers_pkg::REG_MAX_PULSE:     shadow.max_pulse     = d[ers_pkg::PULSE_W-1:0];
            ers_pkg::REG_NEUTRAL_PULSE: shadow.neutral_pulse = d[ers_pkg::PULSE_W-1:0];
            ers_pkg::REG_HALF_BAND:     shadow.half_band     = d[ers_pkg::BAND_W-1:0];
            ers_pkg::REG_BRAKE_TIME:    shadow.brake_time    = d[ers_pkg::TIME_W-1:0];
            ers_pkg::REG_REVERSE_DELAY: shadow.reverse_delay = d[ers_pkg::TIME_W-1:0];
            default: ;         // unmapped index, nothing changes
        endcase
    endfunction

    // ------------------------------------------------------------------
    // random helpers
    // ------------------------------------------------------------------
    function automatic int draw_gap();
        return idle_en ? int'($urandom_range(MAX_GAP, 0)) : 0;
    endfunction

    // pulse width within [lo, hi], any width when that range is empty
    function automatic logic [ers_pkg::PULSE_W-1:0] pulse_in_range(int lo, int hi);
        if (lo < 0) lo = 0;
        if (hi > PULSE_MAX) hi = PULSE_MAX;
        if (lo > hi) return ers_pkg::PULSE_W'($urandom_range(PULSE_MAX, 0));
        return ers_pkg::PULSE_W'($urandom_range(hi, lo));
    endfunction

    function automatic ers_pkg::t_cfg random_settings(bit wild);
        ers_pkg::t_cfg c;
        if (wild) begin
            c.min_pulse     = ers_pkg::PULSE_W'($urandom());
            c.max_pulse     = ers_pkg::PULSE_W'($urandom());
            c.neutral_pulse = ers_pkg::PULSE_W'($urandom());
            c.half_band     = ers_pkg::BAND_W'($urandom());
            c.brake_time    = ers_pkg::TIME_W'($urandom());
            c.reverse_delay = ers_pkg::TIME_W'($urandom());
        end else begin
            // plausible controller setup so that full reverse sequences occur
            c.neutral_pulse = ers_pkg::PULSE_W'($urandom_range(3600, 400));
            c.half_band     = ers_pkg::BAND_W'($urandom_range(300, 0));
            c.min_pulse     = ers_pkg::PULSE_W'($urandom_range(c.neutral_pulse, 0));
            c.max_pulse     = ers_pkg::PULSE_W'($urandom_range(PULSE_MAX, c.neutral_pulse));
            c.brake_time    = ers_pkg::TIME_W'($urandom_range(400, 0));
            c.reverse_delay = ers_pkg::TIME_W'($urandom_range(700, 0));
        end
        return c;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    // one command transfer; valid stays high afterwards so that the next
    // command can follow without a bubble
    task automatic send_cmd(logic [ers_pkg::CHAN_W-1:0] ch, logic [ers_pkg::PULSE_W-1:0] req,
                            logic [ers_pkg::STAMP_W-1:0] now);
        int gap;
        gap = draw_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.channel    <= ch;
        cmd_if.request_us <= req;
        cmd_if.now_ms     <= now;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        expected_q.push_back(predict_pulse(ch, req, now));
    endtask

    task automatic write_reg(logic [ers_pkg::CFG_IDX_W-1:0] idx,
                             logic [ers_pkg::CFG_DATA_W-1:0] d);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= d;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        shadow_write(idx, d);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // stop offering commands and let every outstanding result come back
    task automatic wait_for_results();
        @(negedge i_clk);
        cmd_if.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(ers_pkg::t_cfg c);
        wait_for_results();
        write_reg(ers_pkg::REG_MIN_PULSE,     ers_pkg::CFG_DATA_W'(c.min_pulse));
        write_reg(ers_pkg::REG_MAX_PULSE,     ers_pkg::CFG_DATA_W'(c.max_pulse));
        write_reg(ers_pkg::REG_NEUTRAL_PULSE, ers_pkg::CFG_DATA_W'(c.neutral_pulse));
        write_reg(ers_pkg::REG_HALF_BAND,     ers_pkg::CFG_DATA_W'(c.half_band));
        write_reg(ers_pkg::REG_BRAKE_TIME,    ers_pkg::CFG_DATA_W'(c.brake_time));
        write_reg(ers_pkg::REG_REVERSE_DELAY, ers_pkg::CFG_DATA_W'(c.reverse_delay));
    endtask

    // mostly reverse bursts with advancing time, separated by forward,
    // neutral and fully random commands that re-arm or disturb the channel
    task automatic send_random_cmd();
        logic [ers_pkg::CHAN_W-1:0]  ch;
        logic [ers_pkg::PULSE_W-1:0] req;
        int                          lower_edge;
        int                          upper_edge;
        int                          span;
        int                          pick;
        ch         = ers_pkg::CHAN_W'($urandom_range(NCH - 1, 0));
        lower_edge = int'(shadow.neutral_pulse) - int'(shadow.half_band);
        upper_edge = int'(shadow.neutral_pulse) + int'(shadow.half_band);
        span       = (shadow.brake_time > shadow.reverse_delay) ? int'(shadow.brake_time)
                                                                 : int'(shadow.reverse_delay);
        chan_clock[ch] += $urandom_range(span / 3 + 2, 0);
        if ($urandom_range(19, 0) == 0) chan_clock[ch] = $urandom();
        if (rev_burst[ch] > 0) begin
            rev_burst[ch]--;
            req = pulse_in_range(0, lower_edge);
        end else begin
            if ($urandom_range(9, 0) < 6) rev_burst[ch] = $urandom_range(10, 2);
            pick = $urandom_range(9, 0);
            if (pick < 4) begin
                req = pulse_in_range(upper_edge, PULSE_MAX);
            end else if (pick < 7) begin
                req = pulse_in_range(lower_edge + 1, upper_edge - 1);
            end else begin
                req = ers_pkg::PULSE_W'($urandom_range(PULSE_MAX, 0));
            end
        end
        send_cmd(ch, req, chan_clock[ch]);
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    task automatic note_mismatch(string field, int want, int seen);
        mismatch_cnt++;
        $error("%s: expected %0d, got %0d", field, want, seen);
    endtask

    // receiver ready, driven at the falling edge
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            res_if.ready <= 1'b0;
            rx_hold_left--;
        end else if (rx_stall_left > 0) begin
            res_if.ready <= 1'b0;
            rx_stall_left--;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // score every result transfer against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_q.size() == 0) begin
                note_mismatch("unexpected result, pulse_us", -1, int'(res_if.pulse_us));
            end else begin
                got_exp = expected_q.pop_front();
                if (res_if.out_channel !== got_exp.out_channel) begin
                    note_mismatch("out_channel", int'(got_exp.out_channel),
                                  int'(res_if.out_channel));
                end
                if (res_if.pulse_us !== got_exp.pulse_us) begin
                    note_mismatch("pulse_us", int'(got_exp.pulse_us), int'(res_if.pulse_us));
                end
                if (res_if.phase !== got_exp.phase) begin
                    note_mismatch("phase", int'(got_exp.phase), int'(res_if.phase));
                end
            end
            rx_stall_left = draw_gap();
        end
    end

    // watchdog
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_cnt, expected_q.size());
        $display("[esc_reverse_arming_sequencer] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // default registers: band 1470..1530, brake up to 100 ms, pass after 200 ms
    task automatic test_reset_behavior();
        send_cmd(1'b0, 12'd4095, 32'd0);            // clamped to max, forward
        send_cmd(1'b0, 12'd1500, 32'd5);            // centre, neutral
        send_cmd(1'b0, 12'd0,    32'd10);           // clamped to min, reverse start
        send_cmd(1'b0, 12'd0,    32'd110);          // elapsed equals brake time, brake
        send_cmd(1'b0, 12'd1470, 32'd111);          // band edge counts as reverse, pause
        send_cmd(1'b0, 12'd1200, 32'd210);          // elapsed equals delay, still pause
        send_cmd(1'b0, 12'd1200, 32'd211);          // pass-through
        send_cmd(1'b1, 12'd1300, 32'hFFFF_FFF0);    // start just before the wrap
        send_cmd(1'b1, 12'd1300, 32'h0000_0050);    // wrapped elapsed 96, brake
        send_cmd(1'b0, 12'd1530, 32'hFFFF_FFFF);    // upper band edge, forward
        send_cmd(1'b1, 12'd1300, 32'h0000_00D8);    // wrapped elapsed 232, pass
        send_cmd(1'b1, 12'd1471, 32'h0000_00D9);    // just inside band, re-arms
    endtask

    task automatic test_register_extremes();
        // all ones with bits above every field, then unmapped indexes
        wait_for_results();
        write_reg(ers_pkg::REG_MIN_PULSE,     16'hFFFF);
        write_reg(ers_pkg::REG_MAX_PULSE,     16'hFFFF);
        write_reg(ers_pkg::REG_NEUTRAL_PULSE, 16'hFFFF);
        write_reg(ers_pkg::REG_HALF_BAND,     16'hFFFF);
        write_reg(ers_pkg::REG_BRAKE_TIME,    16'hFFFF);
        write_reg(ers_pkg::REG_REVERSE_DELAY, 16'hFFFF);
        write_reg(REG_SPARE_A,                16'h0000);
        write_reg(REG_SPARE_B,                16'h5A5A);
        send_cmd(1'b0, 12'd0,    32'd0);
        send_cmd(1'b1, 12'd4095, 32'hFFFF_FFFF);

        // everything zero: every request clamps to zero and counts as forward
        set_config('{12'd0, 12'd0, 12'd0, 10'd0, 16'd0, 16'd0});
        send_cmd(1'b0, 12'd4095, 32'd1);
        send_cmd(1'b1, 12'd0,    32'd2);

        // inverted limits and a band reaching below zero
        set_config('{12'd3000, 12'd500, 12'd10, 10'd500, 16'd100, 16'd200});
        send_cmd(1'b0, 12'd100,  32'd3);
        send_cmd(1'b1, 12'd3500, 32'd4);
        send_cmd(1'b0, 12'd2999, 32'd5);

        // reverse delay shorter than brake time, pause never reached
        set_config('{12'd1000, 12'd2000, 12'd1500, 10'd30, 16'd50, 16'd20});
        send_cmd(1'b0, 12'd1000, 32'd1000);
        send_cmd(1'b0, 12'd900,  32'd1010);
        send_cmd(1'b0, 12'd1400, 32'd1021);
        send_cmd(1'b1, 12'd1000, 32'd500);
        send_cmd(1'b1, 12'd1000, 32'd520);

        // zero brake and delay: brake only at zero elapsed
        set_config('{12'd1000, 12'd2000, 12'd1500, 10'd30, 16'd0, 16'd0});
        send_cmd(1'b0, 12'd1800, 32'd7);
        send_cmd(1'b0, 12'd1100, 32'd7);
        send_cmd(1'b0, 12'd1100, 32'd7);
        send_cmd(1'b0, 12'd1100, 32'd8);
    endtask

    task automatic test_reverse_sequences();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            // every third phase runs without gaps or stalls
            idle_en = (p % 3 != 1);
            if (p == 0) begin
                set_config(RESET_SETTINGS);
            end else begin
                set_config(random_settings(p % 4 == 3));
            end
            for (int k = 0; k < NCH; k++) begin
                chan_clock[k] = $urandom_range(1, 0) ? 32'hFFFF_FFFF - $urandom_range(2000, 0)
                                                     : $urandom();
                rev_burst[k]  = 0;
            end
            repeat (PHASE_ITEMS) send_random_cmd();
        end
    endtask

    task automatic test_backpressure();
        set_config(random_settings(1'b0));
        // receiver holds off while commands keep coming back to back
        idle_en      = 1'b0;
        rx_hold_left = 60;
        repeat (40) send_random_cmd();
        idle_en = 1'b1;
        repeat (40) send_random_cmd();
        // sender pauses until the pipeline is empty
        wait_for_results();
        repeat (40) send_random_cmd();
        rx_hold_left = 30;
        repeat (40) send_random_cmd();
    endtask

    initial begin
        cmd_if.valid      = 1'b0;
        cmd_if.channel    = '0;
        cmd_if.request_us = '0;
        cmd_if.now_ms     = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = ers_pkg::REG_MIN_PULSE;
        cfg_if.data       = '0;
        res_if.ready      = 1'b0;
        idle_en           = 1'b1;
        rx_stall_left     = 0;
        rx_hold_left      = 0;
        mismatch_cnt      = 0;
        shadow            = RESET_SETTINGS;
        for (int k = 0; k < NCH; k++) begin
            armed_q[k]     = 1'b1;
            rev_start_q[k] = '0;
            chan_clock[k]  = '0;
            rev_burst[k]   = 0;
        end

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_behavior();
        test_register_extremes();
        test_reverse_sequences();
        test_backpressure();
        wait_for_results();

        if (mismatch_cnt == 0) begin
            $display("[esc_reverse_arming_sequencer] OK");
        end else begin
            $display("[esc_reverse_arming_sequencer] ERROR");
        end
        $finish;
    end

endmodule
